@@ rtl/mtf_pkg.sv @@
// Shared constants and control types for the move-to-front position block.
package mtf_pkg;

  localparam int MAX_SYMBOLS = 256;
  localparam int SYM_W       = 8;
  localparam int POS_W       = $clog2(MAX_SYMBOLS);
  localparam int ALPHA_W     = 9;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(MAX_SYMBOLS);

  typedef struct packed {
    logic capture;  // request accepted: look up and register
    logic move;     // apply move-to-front and load the result register
  } mtf_cmd_t;

  typedef struct packed {
    logic out_busy; // result register holds a result not yet taken
  } mtf_status_t;

endpackage

@@ rtl/mtf_if.sv @@
// Valid/ready channel interfaces for symbol requests and position results.
interface mtf_sym_if;
  logic                     valid;
  logic                     ready;
  logic [mtf_pkg::SYM_W-1:0] symbol;
  logic                     restart;

  modport source (output valid, output symbol, output restart, input ready);
  modport sink   (input valid, input symbol, input restart, output ready);
endinterface

interface mtf_pos_if;
  logic                     valid;
  logic                     ready;
  logic [mtf_pkg::POS_W-1:0] position;
  logic                     bad_symbol;

  modport source (output valid, output position, output bad_symbol, input ready);
  modport sink   (input valid, input position, input bad_symbol, output ready);
endinterface

@@ rtl/move_to_front_position.sv @@
// Top level of the move-to-front position encoder.
//
//   channel    dir   handshake      payload
//   sym_chan   in    valid/ready    symbol[7:0], restart
//   pos_chan   out   valid/ready    position[7:0], bad_symbol
//   cfg        in    cfg_we         cfg_wdata[8:0] = alphabet_size
//
// Per request, a lookup step matches the symbol against all 256 list cells and
// encodes its position; a move step shifts the list, loads the result register.
// A new request is taken while an older result still waits on pos_chan.
// A stalled pos_chan holds the block in its move step until the result is taken.
// Reset (rst, synchronous) loads the identity order and an alphabet of 256.
module move_to_front_position (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mtf_pkg::ALPHA_W-1:0] cfg_wdata,
  mtf_sym_if.sink                     sym_chan,
  mtf_pos_if.source                   pos_chan
);

  mtf_pkg::mtf_cmd_t    cmd;
  mtf_pkg::mtf_status_t status;

  mtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sym_chan.valid),
    .in_ready  (sym_chan.ready),
    .out_valid (pos_chan.valid),
    .out_ready (pos_chan.ready),
    .cmd       (cmd),
    .status    (status)
  );

  mtf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .symbol     (sym_chan.symbol),
    .restart    (sym_chan.restart),
    .position   (pos_chan.position),
    .bad_symbol (pos_chan.bad_symbol)
  );

endmodule

@@ rtl/mtf_ctrl.sv @@
// Controller: sequences lookup and move, owns the result valid flag.
module mtf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mtf_pkg::mtf_cmd_t    cmd,
  output mtf_pkg::mtf_status_t status
);

  typedef enum logic {
    S_IDLE,
    S_MOVE
  } state_t;

  state_t state;

  assign in_ready        = (state == S_IDLE);
  assign cmd.capture     = in_valid && in_ready;
  // the move waits while an earlier result still sits unread
  assign cmd.move        = (state == S_MOVE) && (!out_valid || out_ready);
  assign status.out_busy = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (cmd.move) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/mtf_dp.sv @@
// Datapath: symbol list cells, parallel match and encode, shift, result register.
module mtf_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  mtf_pkg::mtf_cmd_t           cmd,
  input  mtf_pkg::mtf_status_t        status,
  input  logic                        cfg_we,
  input  logic [mtf_pkg::ALPHA_W-1:0] cfg_wdata,
  input  logic [mtf_pkg::SYM_W-1:0]   symbol,
  input  logic                        restart,
  output logic [mtf_pkg::POS_W-1:0]   position,
  output logic                        bad_symbol
);

  // cell i holds (symbol - 1) of the symbol at list position i
  logic [mtf_pkg::POS_W-1:0]       cells [mtf_pkg::MAX_SYMBOLS];
  logic [mtf_pkg::ALPHA_W-1:0]     alpha;
  logic [mtf_pkg::POS_W-1:0]       found;
  logic [mtf_pkg::POS_W-1:0]       key;
  logic                            bad;
  logic [mtf_pkg::POS_W-1:0]       sym_m1;
  logic [mtf_pkg::MAX_SYMBOLS-1:0] match;
  logic [mtf_pkg::POS_W-1:0]       hit_pos;
  logic                            sym_bad;

  assign sym_m1  = mtf_pkg::POS_W'(symbol - 1'b1);
  // symbol 0 is always rejected; an alphabet of 255 or more accepts every other 8-bit symbol
  assign sym_bad = (symbol == '0) || ({1'b0, symbol} > alpha);

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < mtf_pkg::MAX_SYMBOLS; i++) begin
      match[i] = (cells[i] == sym_m1);
      if (match[i]) begin
        hit_pos = hit_pos | mtf_pkg::POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= mtf_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      alpha <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      found <= restart ? sym_m1 : hit_pos;
      key   <= sym_m1;
      bad   <= sym_bad;
    end
    if (cmd.move && !status.out_busy || cmd.move) begin
      position   <= bad ? '0 : found;
      bad_symbol <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mtf_pkg::MAX_SYMBOLS; i++) begin
        cells[i] <= mtf_pkg::POS_W'(i);
      end
    end else if (cmd.capture && restart) begin
      for (int i = 0; i < mtf_pkg::MAX_SYMBOLS; i++) begin
        cells[i] <= mtf_pkg::POS_W'(i);
      end
    end else if (cmd.move && !bad) begin
      // everything ahead of the hit slides back one place
      cells[0] <= key;
      for (int i = 1; i < mtf_pkg::MAX_SYMBOLS; i++) begin
        if (mtf_pkg::POS_W'(i) <= found) begin
          cells[i] <= cells[i-1];
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for move_to_front_position: list-tracking scoreboard and random request traffic.

class position_scoreboard;
  typedef struct packed {
    logic [mtf_pkg::POS_W-1:0] position;
    logic                      bad_symbol;
  } pos_result_t;

  // slot_of[s-1] is the current list position of symbol s
  bit [mtf_pkg::POS_W-1:0]   slot_of[mtf_pkg::MAX_SYMBOLS];
  bit [mtf_pkg::ALPHA_W-1:0] alphabet;
  pos_result_t               pending[$];
  int                        failures;
  int                        checked;
  int                        bad_seen;
  int                        deepest;

  function new();
    alphabet = mtf_pkg::ALPHA_RESET;
    failures = 0;
    checked  = 0;
    bad_seen = 0;
    deepest  = 0;
    load_identity();
  endfunction

  function void load_identity();
    for (int i = 0; i < mtf_pkg::MAX_SYMBOLS; i++) begin
      slot_of[i] = mtf_pkg::POS_W'(i);
    end
  endfunction

  function int symbol_limit();
    return (alphabet > mtf_pkg::MAX_SYMBOLS) ? mtf_pkg::MAX_SYMBOLS : int'(alphabet);
  endfunction

  function void note_request(logic [mtf_pkg::SYM_W-1:0] sym, logic restart);
    pos_result_t             want;
    int                      lim;
    bit [mtf_pkg::POS_W-1:0] found;
    lim = symbol_limit();
    if (restart) begin
      load_identity();
    end
    want.position   = '0;
    want.bad_symbol = 1'b1;
    if (sym != 0 && int'(sym) <= lim) begin
      found = slot_of[int'(sym) - 1];
      foreach (slot_of[i]) begin
        if (slot_of[i] < found) slot_of[i]++;
      end
      slot_of[int'(sym) - 1] = '0;
      want.position   = found;
      want.bad_symbol = 1'b0;
    end
    pending = {pending, want};
  endfunction

  function void check_result(logic [mtf_pkg::POS_W-1:0] position, logic bad_symbol);
    pos_result_t want;
    if (pending.size() == 0) begin
      $error("result with nothing pending: position %0d bad_symbol %0b", position, bad_symbol);
      failures++;
      return;
    end
    want = pending.pop_front();
    checked++;
    if (position !== want.position) begin
      $error("position: expected %0d, actual %0d", want.position, position);
      failures++;
    end
    if (bad_symbol !== want.bad_symbol) begin
      $error("bad_symbol: expected %0b, actual %0b", want.bad_symbol, bad_symbol);
      failures++;
    end
    if (want.bad_symbol) bad_seen++;
    else if (int'(want.position) > deepest) deepest = int'(want.position);
  endfunction

  function void close_out();
    if (pending.size() != 0) begin
      $error("%0d results never arrived", pending.size());
      failures += pending.size();
    end
  endfunction
endclass

module tb_top;

  localparam int STALL_PCT      = 13;
  localparam int HOLD_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [mtf_pkg::ALPHA_W-1:0] cfg_wdata;

  mtf_sym_if sym_chan();
  mtf_pos_if pos_chan();

  move_to_front_position DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sym_chan  (sym_chan),
    .pos_chan  (pos_chan)
  );

  position_scoreboard        sb;
  bit                        sender_calm;
  bit                        receiver_calm;
  int                        sent;
  int                        restarts_sent;
  int                        settings_used;
  int                        idle_cycles;
  logic [mtf_pkg::SYM_W-1:0] recent[$];

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result side: random back-pressure, checked on the rising edge
  always @(negedge clk) begin
    pos_chan.ready = receiver_calm || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (!rst && pos_chan.valid && pos_chan.ready) begin
      sb.check_result(pos_chan.position, pos_chan.bad_symbol);
    end
  end

  always @(posedge clk) begin
    if (rst || (sym_chan.valid && sym_chan.ready) || (pos_chan.valid && pos_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [mtf_pkg::SYM_W-1:0] sym, input logic restart);
    @(negedge clk);
    while (!sender_calm && $urandom_range(0, 99) < STALL_PCT) begin
      sym_chan.valid = 1'b0;
      @(negedge clk);
    end
    sym_chan.valid   = 1'b1;
    sym_chan.symbol  = sym;
    sym_chan.restart = restart;
    do @(posedge clk); while (!sym_chan.ready);
    if (sym != 0 && int'(sym) <= sb.symbol_limit()) begin
      recent = {recent, sym};
      if (recent.size() > 12) void'(recent.pop_front());
    end
    sb.note_request(sym, restart);
    sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    sym_chan.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // only while idle: drain, let the move step finish, then write
  task automatic write_alphabet(input logic [mtf_pkg::ALPHA_W-1:0] value);
    wait_for_results();
    repeat (HOLD_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.alphabet = value;
    settings_used++;
    recent.delete();
  endtask

  // mostly recently used symbols and in-range ones, some out of range
  function automatic logic [mtf_pkg::SYM_W-1:0] pick_symbol(int lim);
    int roll;
    int top;
    roll = $urandom_range(0, 99);
    top  = (lim > 255) ? 255 : lim;
    if (lim == 0) return mtf_pkg::SYM_W'($urandom_range(0, 255));
    if (roll < 40 && recent.size() != 0) return recent[$urandom_range(0, recent.size() - 1)];
    if (roll < 85) return mtf_pkg::SYM_W'($urandom_range(1, top));
    if (roll < 90) return '0;
    if (lim < 255) return mtf_pkg::SYM_W'($urandom_range(lim + 1, 255));
    return mtf_pkg::SYM_W'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(input logic [mtf_pkg::ALPHA_W-1:0] alpha, input int count,
                           input bit calm, input int pause_at);
    write_alphabet(alpha);
    sender_calm   = calm;
    receiver_calm = calm;
    for (int i = 0; i < count; i++) begin
      send_request(pick_symbol(sb.symbol_limit()), $urandom_range(0, 99) < 3);
      if (i == pause_at) wait_for_results();
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    sym_chan.valid   = 1'b0;
    sym_chan.symbol  = '0;
    sym_chan.restart = 1'b0;
    pos_chan.ready   = 1'b0;
    sender_calm      = 1'b0;
    receiver_calm    = 1'b0;
    sent             = 0;
    restarts_sent    = 0;
    settings_used    = 0;
    idle_cycles      = 0;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: repeats, list ends, zero symbol, restarts, alternating bits
    send_request(8'd1, 1'b0);
    send_request(8'd1, 1'b0);
    send_request(8'd2, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd0, 1'b0);
    send_request(8'd0, 1'b1);
    send_request(8'd255, 1'b0);
    send_request(8'd128, 1'b0);
    send_request(8'd1, 1'b0);
    send_request(8'd170, 1'b0);
    send_request(8'd85, 1'b0);
    send_request(8'd1, 1'b1);
    send_request(8'd2, 1'b1);
    send_request(8'd254, 1'b0);
    // symbols just past a small alphabet, then empty and oversized alphabets
    write_alphabet(9'd5);
    send_request(8'd5, 1'b0);
    send_request(8'd6, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd1, 1'b1);
    write_alphabet(9'd0);
    send_request(8'd1, 1'b0);
    send_request(8'd0, 1'b0);
    write_alphabet(9'd511);
    send_request(8'd255, 1'b0);
    send_request(8'd0, 1'b0);

    run_phase(9'd256, 400, 1'b0, 200);
    run_phase(9'd1, 60, 1'b0, -1);
    run_phase(9'd0, 40, 1'b0, -1);
    run_phase(9'd511, 300, 1'b1, -1);
    run_phase(9'd17, 200, 1'b0, -1);
    run_phase(9'd2, 80, 1'b0, -1);
    run_phase(9'd300, 250, 1'b0, -1);
    run_phase(9'd255, 300, 1'b0, 150);
    run_phase(9'd128, 220, 1'b0, -1);

    wait_for_results();
    repeat (8) @(posedge clk);
    sb.close_out();
    $display("Sent %0d symbols (%0d with restart) over %0d alphabet writes from 0 to 511",
             sent, restarts_sent, settings_used);
    $display("Checked %0d positions: %0d out of range, deepest hit at position %0d",
             sb.checked, sb.bad_seen, sb.deepest);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/mtf_pkg.sv
rtl/mtf_if.sv
rtl/mtf_ctrl.sv
rtl/mtf_dp.sv
rtl/move_to_front_position.sv
tb/sv/tb_top.sv
